// File: rtl/ffia_pkg.sv
// ----------------------------------------------------------------------------
// ffia_pkg
// Shared types and constants for the fifo free id allocator.
// ----------------------------------------------------------------------------
package ffia_pkg;

  // pool capacity and field widths
  localparam int unsigned MAX_IDS = 256;
  localparam int unsigned ID_W    = $clog2(MAX_IDS);
  localparam int unsigned CNT_W   = $clog2(MAX_IDS + 1);

  localparam logic [CNT_W-1:0] MAX_CNT       = CNT_W'(MAX_IDS);
  localparam logic [CNT_W-1:0] INIT_SIZE_RST = CNT_W'(200);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_GROW  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_ALLOC = 2'd2,
    ST_BAD_GROW  = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input word
    logic init;       // clear pointers, counts and the map clearing counter
    logic exec;       // commit a one-step operation and emit its result
    logic push;       // append the next id of a fill or grow
    logic clear;      // clear the next allocation map entry
    logic emit_grow;  // emit the result of a finished grow
  } ffia_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic grow_ok;    // captured word is a legal grow
    logic grow_done;  // pool size reached the fill or grow target
    logic clr_done;   // every allocation map entry has been cleared
  } ffia_sts_t;

endpackage

// File: rtl/ffia_ctrl.sv
// ----------------------------------------------------------------------------
// ffia_ctrl
// Sequencer: start fill, single-step operations and walking grows.
// ----------------------------------------------------------------------------
module ffia_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                cfg_wr_en,
  input  ffia_pkg::ffia_sts_t sts,
  output ffia_pkg::ffia_cmd_t cmd,
  output logic                busy
);

  typedef enum logic [4:0] {
    S_INIT = 5'b00001,
    S_FILL = 5'b00010,
    S_IDLE = 5'b00100,
    S_EXEC = 5'b01000,
    S_GROW = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // a register write restarts the pool and blocks a start in the same cycle
  assign busy = (state_r != S_IDLE) || cfg_wr_en;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_FILL;
      end
      S_FILL: begin
        // ring refill runs alongside the full allocation map clear
        if (sts.grow_done && sts.clr_done) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.push  = !sts.grow_done;
          cmd.clear = !sts.clr_done;
        end
      end
      S_IDLE: begin
        if (start && !busy) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.grow_ok) begin
          state_nxt = S_GROW;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_GROW: begin
        if (sts.grow_done) begin
          cmd.emit_grow = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.push = 1'b1;
        end
      end
      default: state_nxt = S_INIT;
    endcase
    if (cfg_wr_en) begin
      state_nxt = S_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/ffia_dpath.sv
// ----------------------------------------------------------------------------
// ffia_dpath
// Free ring memory, pointers, counters, allocation map and result register.
// ----------------------------------------------------------------------------
module ffia_dpath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [ffia_pkg::CNT_W-1:0]       cfg_wr_data,
  input  logic [1:0]                       in_opcode,
  input  logic [ffia_pkg::ID_W-1:0]        in_index,
  input  logic [ffia_pkg::CNT_W-1:0]       in_new_size,
  input  ffia_pkg::ffia_cmd_t              cmd,
  output ffia_pkg::ffia_sts_t              sts,
  output logic                             out_valid,
  output logic [ffia_pkg::ID_W-1:0]        out_granted_id,
  output logic [1:0]                       out_status,
  output logic [ffia_pkg::CNT_W-1:0]       out_free_count,
  output logic [ffia_pkg::CNT_W-1:0]       out_pool_size
);

  localparam int unsigned IW = ffia_pkg::ID_W;
  localparam int unsigned CW = ffia_pkg::CNT_W;

  logic [IW-1:0] ring_mem [ffia_pkg::MAX_IDS];
  logic [IW-1:0] rd_data_r;
  logic          map_mem  [ffia_pkg::MAX_IDS];
  logic          map_rd_r;

  logic [CW-1:0]         init_size_r;
  ffia_pkg::opcode_t     op_r;
  logic [IW-1:0]         idx_r;
  logic [CW-1:0]         nsize_r;
  logic [IW-1:0]         head_r, head_nxt;
  logic [IW-1:0]         tail_r, tail_nxt;
  logic [CW-1:0]         free_r, free_nxt;
  logic [CW-1:0]         size_r, size_nxt;
  logic [CW-1:0]         target_r, target_nxt;
  logic [CW-1:0]         clr_r, clr_nxt;

  logic                  valid_r, valid_nxt;
  logic [IW-1:0]         granted_r, granted_nxt;
  ffia_pkg::status_t     status_r, status_nxt;
  logic [CW-1:0]         fcnt_r, fcnt_nxt;
  logic [CW-1:0]         psize_r, psize_nxt;

  logic                  mem_we;
  logic [IW-1:0]         mem_wd;
  logic                  map_we;
  logic [IW-1:0]         map_wa;
  logic                  map_wd;
  logic [CW-1:0]         sat_init;
  logic                  free_ok;
  logic                  grow_legal;

  // sizes above capacity saturate
  assign sat_init   = (init_size_r > ffia_pkg::MAX_CNT) ? ffia_pkg::MAX_CNT : init_size_r;
  assign free_ok    = map_rd_r && (free_r < ffia_pkg::MAX_CNT);
  assign grow_legal = (nsize_r >= size_r) && (nsize_r <= ffia_pkg::MAX_CNT);

  assign sts.grow_ok   = (op_r == ffia_pkg::OP_GROW) && grow_legal;
  assign sts.grow_done = (size_r == target_r);
  assign sts.clr_done  = (clr_r == ffia_pkg::MAX_CNT);

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    free_nxt    = free_r;
    size_nxt    = size_r;
    target_nxt  = target_r;
    clr_nxt     = clr_r;
    valid_nxt   = 1'b0;
    granted_nxt = granted_r;
    status_nxt  = status_r;
    fcnt_nxt    = fcnt_r;
    psize_nxt   = psize_r;
    mem_we      = 1'b0;
    mem_wd      = size_r[IW-1:0];
    map_we      = 1'b0;
    map_wa      = clr_r[IW-1:0];
    map_wd      = 1'b0;

    if (cmd.load) begin
      target_nxt = in_new_size;
    end

    if (cmd.init) begin
      head_nxt   = '0;
      tail_nxt   = '0;
      free_nxt   = '0;
      size_nxt   = '0;
      clr_nxt    = '0;
      target_nxt = sat_init;
    end

    if (cmd.push) begin
      mem_we   = 1'b1;
      mem_wd   = size_r[IW-1:0];
      tail_nxt = tail_r + 1'b1;
      free_nxt = free_r + 1'b1;
      size_nxt = size_r + 1'b1;
    end

    // one map entry cleared per cycle during a restart
    if (cmd.clear) begin
      map_we  = 1'b1;
      map_wa  = clr_r[IW-1:0];
      map_wd  = 1'b0;
      clr_nxt = clr_r + 1'b1;
    end

    if (cmd.exec) begin
      granted_nxt = '0;
      status_nxt  = ffia_pkg::ST_OK;
      unique case (op_r)
        ffia_pkg::OP_ALLOC: begin
          if (free_r == '0) begin
            status_nxt = ffia_pkg::ST_EMPTY;
          end else begin
            granted_nxt = rd_data_r;
            head_nxt    = head_r + 1'b1;
            free_nxt    = free_r - 1'b1;
            map_we      = 1'b1;
            map_wa      = rd_data_r;
            map_wd      = 1'b1;
          end
        end
        ffia_pkg::OP_FREE: begin
          if (free_ok) begin
            map_we   = 1'b1;
            map_wa   = idx_r;
            map_wd   = 1'b0;
            mem_we   = 1'b1;
            mem_wd   = idx_r;
            tail_nxt = tail_r + 1'b1;
            free_nxt = free_r + 1'b1;
          end else begin
            status_nxt = ffia_pkg::ST_NOT_ALLOC;
          end
        end
        // legal grows go through the walk, only rejected ones land here
        ffia_pkg::OP_GROW: status_nxt = ffia_pkg::ST_BAD_GROW;
        ffia_pkg::OP_NONE: status_nxt = ffia_pkg::ST_OK;
      endcase
      valid_nxt = 1'b1;
      fcnt_nxt  = free_nxt;
      psize_nxt = size_r;
    end

    if (cmd.emit_grow) begin
      valid_nxt   = 1'b1;
      granted_nxt = '0;
      status_nxt  = ffia_pkg::ST_OK;
      fcnt_nxt    = free_r;
      psize_nxt   = size_r;
    end
  end

  // ring memory: one write port at the tail, registered read at the head
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[tail_r] <= mem_wd;
    end
    rd_data_r <= ring_mem[head_r];
  end

  // allocation map: one write port, registered read of the incoming index
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    if (cmd.load) begin
      map_rd_r <= map_mem[in_index];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_size_r <= ffia_pkg::INIT_SIZE_RST;
      head_r      <= '0;
      tail_r      <= '0;
      free_r      <= '0;
      size_r      <= '0;
      target_r    <= '0;
      clr_r       <= '0;
      valid_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        init_size_r <= cfg_wr_data;
      end
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      free_r   <= free_nxt;
      size_r   <= size_nxt;
      target_r <= target_nxt;
      clr_r    <= clr_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= ffia_pkg::opcode_t'(in_opcode);
      idx_r   <= in_index;
      nsize_r <= in_new_size;
    end
    granted_r <= granted_nxt;
    status_r  <= status_nxt;
    fcnt_r    <= fcnt_nxt;
    psize_r   <= psize_nxt;
  end

  assign out_valid      = valid_r;
  assign out_granted_id = granted_r;
  assign out_status     = status_r;
  assign out_free_count = fcnt_r;
  assign out_pool_size  = psize_r;

endmodule

// File: rtl/fifo_free_id_allocator.sv
// ----------------------------------------------------------------------------
// fifo_free_id_allocator
// Hands out ids from a first-in first-out ring of free ids.
// ----------------------------------------------------------------------------
// sequencing: allocate, free and unused ops pass through the EXEC state and
//   show a registered out_valid; a grow walks the GROW state, one ring write per new id
// throughput: a new word waits until the last one is done, set by the registered
//   ring and map reads; grow is bound by the single ring write port
// reset and cfg write: busy through the INIT and FILL states while the allocation map
//   is cleared one entry a cycle and the ring refills alongside; no result stall
// ----------------------------------------------------------------------------
module fifo_free_id_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration: initial pool size, write restarts the pool
  input  logic                        cfg_wr_en,
  input  logic [ffia_pkg::CNT_W-1:0]  cfg_wr_data,
  // command word
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_opcode,
  input  logic [ffia_pkg::ID_W-1:0]   in_index,
  input  logic [ffia_pkg::CNT_W-1:0]  in_new_size,
  // result word, valid for exactly one cycle
  output logic                        out_valid,
  output logic [ffia_pkg::ID_W-1:0]   out_granted_id,
  output logic [1:0]                  out_status,
  output logic [ffia_pkg::CNT_W-1:0]  out_free_count,
  output logic [ffia_pkg::CNT_W-1:0]  out_pool_size
);

  // command and status between sequencer and datapath
  ffia_pkg::ffia_cmd_t cmd;
  ffia_pkg::ffia_sts_t sts;

  // sequencer: init, fill walk, idle, single-step execute, grow walk
  ffia_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cfg_wr_en (cfg_wr_en),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  // ring memory, head/tail pointers, free count, pool size and allocation map
  ffia_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_opcode      (in_opcode),
    .in_index       (in_index),
    .in_new_size    (in_new_size),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_granted_id (out_granted_id),
    .out_status     (out_status),
    .out_free_count (out_free_count),
    .out_pool_size  (out_pool_size)
  );

endmodule

// File: test/fifo_free_id_allocator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fifo_free_id_allocator_test
// Self-checking bench for the free id allocator. A word-level pool predictor
// tracks the free ring, the allocation marks and the pool size, and each
// result word is compared against it. Directed corners come first, then
// random allocate/free/grow traffic over several pool sizes and idle mixes.
// ----------------------------------------------------------------------------
module fifo_free_id_allocator_test;

  localparam int IW           = ffia_pkg::ID_W;
  localparam int CW           = ffia_pkg::CNT_W;
  localparam int CLK_HALF     = 4;        // 8 ns period
  localparam int RESET_CYCLES = 11;
  localparam int CYCLE_LIMIT  = 5000000;  // far above the slowest legal run
  localparam int DRAIN_LIMIT  = 600;      // room for the longest grow walk
  localparam int MAX_REPORTS  = 10;
  localparam int RESTART_GAP  = 190;      // random words between pool restarts

  // one expected result word
  typedef struct {
    logic [IW-1:0]     granted_id;
    ffia_pkg::status_t status;
    logic [CW-1:0]     free_count;
    logic [CW-1:0]     pool_size;
  } pool_result_t;

  // dut ports, all inputs known from time zero
  logic          clk         = 1'b0;
  logic          rst_n       = 1'b0;
  logic          cfg_wr_en   = 1'b0;
  logic [CW-1:0] cfg_wr_data = '0;
  logic          start       = 1'b0;
  logic [1:0]    in_opcode   = ffia_pkg::OP_NONE;
  logic [IW-1:0] in_index    = '0;
  logic [CW-1:0] in_new_size = '0;
  logic          busy;
  logic          out_valid;
  logic [IW-1:0] out_granted_id;
  logic [1:0]    out_status;
  logic [CW-1:0] out_free_count;
  logic [CW-1:0] out_pool_size;

  // pool predictor state
  logic [IW-1:0] free_ring_q [ffia_pkg::MAX_IDS];
  logic          id_taken    [ffia_pkg::MAX_IDS];
  logic [IW-1:0] ring_rd_ptr;
  logic [IW-1:0] ring_wr_ptr;
  logic [CW-1:0] free_ids;
  logic [CW-1:0] pool_ids;
  logic [IW-1:0] held_ids [$];   // ids currently handed out, used to aim frees

  pool_result_t expected_results [$];

  int idle_pct        = 0;
  int mismatch_count  = 0;
  int results_checked = 0;
  int pool_restarts   = 0;
  int status_seen [4] = '{default: 0};
  int cycle_count     = 0;

  fifo_free_id_allocator u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_index       (in_index),
    .in_new_size    (in_new_size),
    .out_valid      (out_valid),
    .out_granted_id (out_granted_id),
    .out_status     (out_status),
    .out_free_count (out_free_count),
    .out_pool_size  (out_pool_size)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic void append_free_id(input logic [IW-1:0] id);
    free_ring_q[ring_wr_ptr] = id;
    ring_wr_ptr = ring_wr_ptr + 1'b1;   // 8-bit pointer wraps at MAX_IDS
    free_ids = free_ids + 1'b1;
  endfunction

  // restart the pool: ids 0..size-1 free in order, nothing taken
  function automatic void refill_pool(input logic [CW-1:0] size_req);
    logic [CW-1:0] n;
    // oversize saturates
    n = (size_req > ffia_pkg::MAX_CNT) ? ffia_pkg::MAX_CNT : size_req;
    ring_rd_ptr = '0;
    ring_wr_ptr = '0;
    free_ids = '0;
    foreach (id_taken[i]) id_taken[i] = 1'b0;
    held_ids.delete();
    for (int i = 0; i < int'(n); i++) append_free_id(IW'(i));
    pool_ids = n;
  endfunction

  // apply one command word to the predicted pool and return its result word
  function automatic pool_result_t predict_pool_op(input ffia_pkg::opcode_t op,
      input logic [IW-1:0] idx, input logic [CW-1:0] nsz);
    pool_result_t r;
    int pos;
    r.granted_id = '0;
    r.status = ffia_pkg::ST_OK;
    pos = -1;
    unique case (op)
      ffia_pkg::OP_ALLOC: begin
        if (free_ids == 0) begin
          r.status = ffia_pkg::ST_EMPTY;
        end else begin
          r.granted_id = free_ring_q[ring_rd_ptr];
          ring_rd_ptr = ring_rd_ptr + 1'b1;
          free_ids = free_ids - 1'b1;
          id_taken[r.granted_id] = 1'b1;
          held_ids.push_back(r.granted_id);
        end
      end
      ffia_pkg::OP_FREE: begin
        // only a handed-out id goes back; double or stray frees are rejected
        if (id_taken[idx] && free_ids < ffia_pkg::MAX_CNT) begin
          id_taken[idx] = 1'b0;
          append_free_id(idx);
          foreach (held_ids[k]) if (held_ids[k] == idx) pos = k;
          if (pos >= 0) held_ids.delete(pos);
        end else begin
          r.status = ffia_pkg::ST_NOT_ALLOC;
        end
      end
      ffia_pkg::OP_GROW: begin
        // no shrinking and no growth past capacity; same size is a no-op
        if (nsz < pool_ids || nsz > ffia_pkg::MAX_CNT) begin
          r.status = ffia_pkg::ST_BAD_GROW;
        end else begin
          for (int i = int'(pool_ids); i < int'(nsz); i++) append_free_id(IW'(i));
          pool_ids = nsz;
        end
      end
      default: ;  // unused opcode: nothing changes
    endcase
    r.free_count = free_ids;
    r.pool_size = pool_ids;
    return r;
  endfunction

  // ---------------------------------------------------------------- checker

  // results cannot be held off, so every strobe is taken at the edge it ends on
  always @(posedge clk) begin : check_results
    pool_result_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result word: id %0d status %0d free %0d pool %0d",
                   out_granted_id, out_status, out_free_count, out_pool_size);
      end else begin
        exp_r = expected_results[0];
        expected_results.delete(0);
        results_checked++;
        if (out_granted_id !== exp_r.granted_id || out_status !== exp_r.status ||
            out_free_count !== exp_r.free_count ||
            out_pool_size !== exp_r.pool_size) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"word %0d: exp id %0d status %0d free %0d pool %0d, ",
                      "got id %0d status %0d free %0d pool %0d"},
                     results_checked, exp_r.granted_id, exp_r.status, exp_r.free_count,
                     exp_r.pool_size, out_granted_id, out_status, out_free_count,
                     out_pool_size);
        end
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  // send one command word; start stays high afterwards so back-to-back words
  // need no low cycle, and whoever acts next owns the next falling edge
  task automatic send_word(input ffia_pkg::opcode_t op, input logic [IW-1:0] idx,
                           input logic [CW-1:0] nsz);
    pool_result_t exp_r;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start       <= 1'b0;
      in_opcode   <= 2'($urandom);   // junk while idle, must be ignored
      in_index    <= IW'($urandom);
      in_new_size <= CW'($urandom);
    end
    @(negedge clk);
    start       <= 1'b1;
    in_opcode   <= op;
    in_index    <= idx;
    in_new_size <= nsz;
    do @(posedge clk); while (busy);
    exp_r = predict_pool_op(op, idx, nsz);
    expected_results.push_back(exp_r);
    status_seen[exp_r.status]++;
  endtask

  // drop start and wait for every outstanding word; stragglers count as failures
  task automatic drain_results();
    int waited;
    @(negedge clk);
    start <= 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_results.size() != 0) begin
      $display("%0d expected result words never arrived", expected_results.size());
      mismatch_count += expected_results.size();
      expected_results.delete();
    end
  endtask

  // write initial_size while idle; the block refills its ring right away
  task automatic write_pool_size(input logic [CW-1:0] size_req);
    drain_results();
    do @(posedge clk); while (busy);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= size_req;
    refill_pool(size_req);
    pool_restarts++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  // default pool of 200 after reset: order, double free, grow limits
  task automatic test_reset_pool();
    send_word(ffia_pkg::OP_ALLOC, '0, '0);
    send_word(ffia_pkg::OP_ALLOC, '0, '0);
    send_word(ffia_pkg::OP_FREE, 8'd1, '0);
    send_word(ffia_pkg::OP_FREE, 8'd1, '0);     // freed twice
    send_word(ffia_pkg::OP_FREE, 8'd255, '0);   // outside the pool, never handed out
    send_word(ffia_pkg::OP_FREE, 8'd0, '0);
    send_word(ffia_pkg::OP_GROW, '0, 9'd199);   // shrink rejected
    send_word(ffia_pkg::OP_GROW, '0, 9'd200);   // same size, no change
    send_word(ffia_pkg::OP_GROW, '0, 9'd257);   // past capacity
    send_word(ffia_pkg::OP_GROW, '0, 9'd511);
    send_word(ffia_pkg::OP_GROW, '0, 9'd256);   // fill to capacity
    send_word(ffia_pkg::OP_NONE, 8'hff, 9'h1ff);
    drain_results();
  endtask

  // empty, single-id, saturated and full pools
  task automatic test_size_extremes();
    write_pool_size(9'd0);
    send_word(ffia_pkg::OP_ALLOC, '0, '0);      // nothing to hand out
    send_word(ffia_pkg::OP_FREE, 8'd0, '0);
    send_word(ffia_pkg::OP_GROW, '0, 9'd0);
    send_word(ffia_pkg::OP_GROW, '0, 9'd1);
    send_word(ffia_pkg::OP_ALLOC, '0, '0);
    send_word(ffia_pkg::OP_ALLOC, '0, '0);
    write_pool_size(9'd511);                    // clamps to capacity
    send_word(ffia_pkg::OP_ALLOC, '0, '0);
    send_word(ffia_pkg::OP_FREE, 8'd0, '0);
    send_word(ffia_pkg::OP_GROW, '0, 9'd256);
    write_pool_size(9'd1);
    send_word(ffia_pkg::OP_ALLOC, '0, '0);
    send_word(ffia_pkg::OP_ALLOC, '0, '0);
    write_pool_size(9'd256);
    send_word(ffia_pkg::OP_GROW, '0, 9'd255);
    drain_results();
  endtask

  // mostly aimed frees and small grows so the pool keeps draining and refilling;
  // the pool is restarted every so often with a fresh, mostly small, size
  task automatic test_random_traffic(input int pct, input int n_words);
    ffia_pkg::opcode_t op;
    logic [IW-1:0]     idx;
    logic [CW-1:0]     nsz;
    int                roll;
    idle_pct = pct;
    for (int k = 0; k < n_words; k++) begin
      if (k % RESTART_GAP == 0)
        write_pool_size(($urandom_range(9) == 0) ? CW'($urandom_range(511))
                                                 : CW'($urandom_range(1, 24)));
      roll = $urandom_range(99);
      idx  = IW'($urandom);
      nsz  = CW'($urandom);
      if (roll < 50) begin
        op = ffia_pkg::OP_ALLOC;
      end else if (roll < 86) begin
        op = ffia_pkg::OP_FREE;
        if (held_ids.size() != 0 && $urandom_range(99) < 85)
          idx = held_ids[$urandom_range(held_ids.size() - 1)];
      end else if (roll < 95) begin
        op = ffia_pkg::OP_GROW;
        if ($urandom_range(99) < 70) nsz = pool_ids + CW'($urandom_range(4));
      end else begin
        op = ffia_pkg::OP_NONE;
      end
      send_word(op, idx, nsz);
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    refill_pool(ffia_pkg::INIT_SIZE_RST);   // the block fills 200 ids on its own

    test_reset_pool();
    test_size_extremes();
    test_random_traffic(22, 570);
    test_random_traffic(73, 570);
    test_random_traffic(0, 560);

    repeat (8) @(posedge clk);    // room for any stray late strobe
    $display("checked %0d result words across %0d pool restarts and three idle mixes",
             results_checked, pool_restarts);
    $display("outcomes: ok %0d, empty pool %0d, rejected free %0d, rejected grow %0d",
             status_seen[ffia_pkg::ST_OK], status_seen[ffia_pkg::ST_EMPTY],
             status_seen[ffia_pkg::ST_NOT_ALLOC], status_seen[ffia_pkg::ST_BAD_GROW]);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
